[src/ksp_pkg.sv]
// ----------------------------------------------------------------------------
// ksp_pkg: shared types and constants for the k-segment partition solver
// Sizes of the reward and value tables and the request/result structs.
// ----------------------------------------------------------------------------
package ksp_pkg;
    localparam int MaxGroups  = 32;
    localparam int IdxW       = 5;
    localparam int CntW       = 6;
    localparam int RewardW    = 32;
    localparam int TotalW     = 37;
    localparam int ValW       = 38;
    localparam int RewAddrW   = 2 * IdxW;
    localparam int DpAddrW    = 2 * CntW;

    localparam logic [0:0] CmdLoad  = 1'b0;
    localparam logic [0:0] CmdSolve = 1'b1;

    typedef struct packed {
        logic [0:0]         cmd;
        logic [IdxW-1:0]    row_index;
        logic [IdxW-1:0]    col_index;
        logic [RewardW-1:0] reward_value;
        logic [CntW-1:0]    segment_count;
    } t_req;

    typedef struct packed {
        logic [IdxW-1:0]   cut_index;
        logic              last_cut;
        logic              feasible;
        logic [TotalW-1:0] best_total;
    } t_res;

    // Flat address of (t, a) in the value and choice tables.
    function automatic logic [DpAddrW-1:0] dp_addr(input logic [CntW-1:0] t,
                                                  input logic [CntW-1:0] a);
        dp_addr = {t, a};
    endfunction
endpackage

[src/ksp_rew_mem.sv]
// ----------------------------------------------------------------------------
// ksp_rew_mem: reward table
// One write port for loads, one registered read port for the solver.
// ----------------------------------------------------------------------------
module ksp_rew_mem (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ksp_pkg::RewAddrW-1:0] i_waddr,
    input  logic [ksp_pkg::RewardW-1:0]  i_wdata,
    input  logic [ksp_pkg::RewAddrW-1:0] i_raddr,
    output logic [ksp_pkg::RewardW-1:0]  o_rdata
);
    import ksp_pkg::*;

    logic [RewardW-1:0] r_mem [0:(1<<RewAddrW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/ksp_dp_mem.sv]
// ----------------------------------------------------------------------------
// ksp_dp_mem: value and choice tables with a valid flag
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module ksp_dp_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ksp_pkg::DpAddrW-1:0] i_waddr,
    input  logic [ksp_pkg::ValW-1:0]    i_wdata,
    input  logic [ksp_pkg::CntW-1:0]    i_wchoice,
    input  logic                        i_wvalid,
    input  logic [ksp_pkg::DpAddrW-1:0] i_raddr,
    output logic [ksp_pkg::ValW-1:0]    o_rdata,
    output logic [ksp_pkg::CntW-1:0]    o_rchoice,
    output logic                        o_rvalid
);
    import ksp_pkg::*;

    logic [ValW+CntW:0] r_mem [0:(1<<DpAddrW)-1];
    logic [ValW+CntW:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wvalid, i_wchoice, i_wdata};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata   = r_rd[ValW-1:0];
    assign o_rchoice = r_rd[ValW+CntW-1:ValW];
    assign o_rvalid  = r_rd[ValW+CntW];
endmodule

[src/k_segment_partition_dp_top.sv]
// ----------------------------------------------------------------------------
// k_segment_partition_dp_top: optimal split of G items into A segments
// Sequencer around one shared add-and-compare unit and two table memories.
// ----------------------------------------------------------------------------
// Channel   Ports                      Handshake
// request   i_start, i_req, o_busy     taken when i_start && !o_busy
// result    o_res_valid, o_res         one cycle each, no back-pressure
// config    i_cfg_we, i_cfg_data       taken when i_cfg_we
//
// A load only writes the reward table. A solve visits each (t, a, e) candidate
// in S_RD and S_ACC and each cell in S_CELL and S_WR (one-segment cells also in
// S_RD and S_ACC), then each result in S_TRD and S_TOUT; an infeasible count
// answers from S_BAD. Candidates and results use the registered table reads.
// Reset clears the sequencer and sets the group count to 32; the tables hold
// no reset. The receiver of results cannot stall.
module k_segment_partition_dp_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ksp_pkg::t_req               i_req,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [ksp_pkg::CntW-1:0]    i_cfg_data,
    output logic                        o_res_valid,
    output ksp_pkg::t_res               o_res
);
    import ksp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CELL  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_TRD   = 8'b0010_0000,
        S_TOUT  = 8'b0100_0000,
        S_BAD   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [CntW-1:0]    r_g, r_areq, r_a, r_t, r_e, r_k;
    logic [ValW-1:0]    r_best;
    logic [CntW-1:0]    r_choice;
    logic               r_bvalid;
    logic [TotalW-1:0]  r_total;
    logic               r_rv;
    t_res               r_res;

    logic               rw_we, dw_we, dw_valid;
    logic [RewardW-1:0] rw_rdata;
    logic [ValW-1:0]    dp_rdata;
    logic [CntW-1:0]    dp_rchoice;
    logic               dp_rvalid;
    logic [DpAddrW-1:0] dp_raddr, dp_waddr;
    logic [ValW-1:0]    dp_wdata;
    logic [CntW-1:0]    dp_wchoice;
    logic [RewAddrW-1:0] rw_raddr;
    logic [ValW-1:0]    cand;
    logic               accept;
    logic [CntW-1:0]    cfg_clamped;
    logic [CntW-1:0]    gm1, e_plus1, a_m1;

    assign accept  = i_start && !o_busy;
    assign o_busy  = (r_state != S_IDLE);
    assign gm1     = r_g - 1'b1;
    assign e_plus1 = r_e + 1'b1;
    assign a_m1    = r_a - 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = CntW'(1);
        end else if (i_cfg_data > CntW'(MaxGroups)) begin
            cfg_clamped = CntW'(MaxGroups);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    assign rw_we = accept && (i_req.cmd == CmdLoad);
    // Reward read: (t, g-1) for one segment, (t, e) otherwise.
    assign rw_raddr = {r_t[IdxW-1:0], (r_a == CntW'(1)) ? gm1[IdxW-1:0] : r_e[IdxW-1:0]};
    assign dp_raddr = (r_state == S_TRD || r_state == S_TOUT) ? dp_addr(r_t, r_k)
                                                              : dp_addr(e_plus1, a_m1);
    // The shared unit: one wide add feeding one compare.
    assign cand = ValW'(rw_rdata) + dp_rdata;

    assign dw_we      = (r_state == S_WR);
    assign dp_waddr   = dp_addr(r_t, r_a);
    assign dp_wdata   = r_best;
    assign dp_wchoice = r_choice;
    assign dw_valid   = r_bvalid;

    ksp_rew_mem u_rew (
        .i_clk   (i_clk),
        .i_we    (rw_we),
        .i_waddr ({i_req.row_index, i_req.col_index}),
        .i_wdata (i_req.reward_value),
        .i_raddr (rw_raddr),
        .o_rdata (rw_rdata)
    );

    ksp_dp_mem u_dp (
        .i_clk     (i_clk),
        .i_we      (dw_we),
        .i_waddr   (dp_waddr),
        .i_wdata   (dp_wdata),
        .i_wchoice (dp_wchoice),
        .i_wvalid  (dw_valid),
        .i_raddr   (dp_raddr),
        .o_rdata   (dp_rdata),
        .o_rchoice (dp_rchoice),
        .o_rvalid  (dp_rvalid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_g     <= CntW'(MaxGroups);
            r_rv    <= 1'b0;
        end else begin
            r_rv <= 1'b0;
            if (i_cfg_we) begin
                r_g <= cfg_clamped;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_req.cmd == CmdSolve) begin
                        r_areq <= i_req.segment_count;
                        if (i_req.segment_count == '0 || i_req.segment_count > r_g) begin
                            r_state <= S_BAD;
                        end else begin
                            r_a     <= CntW'(1);
                            r_t     <= gm1;
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    // Start cell (t, a).
                    r_bvalid <= 1'b0;
                    r_best   <= '0;
                    r_choice <= '0;
                    r_e      <= r_t;
                    if (r_a > r_g - r_t) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_a == CntW'(1)) begin
                        r_best   <= ValW'(rw_rdata);
                        r_choice <= gm1;
                        r_bvalid <= 1'b1;
                        r_state  <= S_WR;
                    end else begin
                        if (dp_rvalid && (!r_bvalid || cand > r_best)) begin
                            r_best   <= cand;
                            r_choice <= r_e;
                            r_bvalid <= 1'b1;
                        end
                        if (r_e + r_a + 1'b1 <= r_g) begin
                            r_e     <= e_plus1;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    if (r_t != '0) begin
                        r_t     <= r_t - 1'b1;
                        r_state <= S_CELL;
                    end else if (r_a != r_areq) begin
                        r_a     <= r_a + 1'b1;
                        r_t     <= gm1;
                        r_state <= S_CELL;
                    end else begin
                        r_t     <= '0;
                        r_k     <= r_areq;
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    r_state <= S_TOUT;
                end
                S_TOUT: begin
                    // The first traceback read carries the best total.
                    if (r_k == r_areq) begin
                        r_total <= dp_rdata[TotalW-1:0];
                    end
                    r_rv <= 1'b1;
                    r_res.cut_index  <= dp_rchoice[IdxW-1:0];
                    r_res.last_cut   <= (r_k == CntW'(1));
                    r_res.feasible   <= 1'b1;
                    r_res.best_total <= (r_k == r_areq) ? dp_rdata[TotalW-1:0] : r_total;
                    if (r_k == CntW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_t     <= dp_rchoice + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_BAD: begin
                    r_rv  <= 1'b1;
                    r_res <= '{cut_index: '0, last_cut: 1'b1, feasible: 1'b0,
                               best_total: '0};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_rv;
    assign o_res       = r_res;

    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g != '0) && (r_g <= CntW'(MaxGroups)))
        else $error("group count out of range");
    a_no_res_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.cmd == CmdLoad) |=> !o_res_valid)
        else $error("load produced a result");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_cut) |-> !o_busy)
        else $error("last result while still busy");
    a_cut_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.feasible && o_res.last_cut) |->
        (o_res.cut_index == gm1[IdxW-1:0]))
        else $error("final cut is not the last item");
endmodule
